/* rtl/psd_pkg.sv */
// ----------------------------------------------------------------------------
// psd_pkg
// Types and constants shared by the port scan detector cells and top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package psd_pkg;

    localparam int PORT_BITS = 10;   // ports below 1024 only
    localparam int KEY_BITS  = 64;
    localparam int THR_BITS  = 5;
    localparam logic [THR_BITS-1:0] THR_RESET = 5'd8;

    localparam logic CMD_PACKET = 1'b0;
    localparam logic CMD_TICK   = 1'b1;

    typedef struct packed {
        logic        command;
        logic [31:0] src_ip;
        logic [31:0] dst_addr;
        logic [15:0] dst_port;
    } item_t;

    typedef struct packed {
        logic scan_detected;
        logic table_full;
    } result_t;

    // control broadcast from the sequencer to every cell
    typedef struct packed {
        logic look;     // compare phase, latch match flags
        logic act;      // update phase
        logic clear;    // minute tick
        logic insert;   // claim lowest free cell
    } cell_op_t;

    // pair cell status back to the top level
    typedef struct packed {
        logic hit;
        logic known;
        logic wrap;
    } pair_stat_t;

endpackage

/* rtl/psd_pair_cell.sv */
// ----------------------------------------------------------------------------
// psd_pair_cell
// One address pair entry: key, distinct-port index and its port slots.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module psd_pair_cell
    import psd_pkg::*;
#(
    parameter int PORTS_PER_PAIR = 16,
    parameter int LW             = 5
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  cell_op_t              op,
    input  logic [KEY_BITS-1:0]   key,
    input  logic [PORT_BITS-1:0]  port,
    input  logic                  pkt,
    input  logic [LW-1:0]         limit,
    input  logic                  free_in,
    output logic                  free_out,
    output pair_stat_t            stat
);

    localparam int IW = $clog2(PORTS_PER_PAIR);

    logic                 valid_reg, valid_next;
    logic [KEY_BITS-1:0]  key_reg;
    logic [IW-1:0]        idx_reg;
    logic [PORT_BITS-1:0] ports_reg [PORTS_PER_PAIR];
    logic                 hit_reg, known_reg, wrap_reg;
    logic                 known_c;
    logic                 claim;

    always_comb
    begin
        known_c = 1'b0;
        for (int j = 0; j < PORTS_PER_PAIR; j++)
        begin
            if (IW'(j) <= idx_reg && ports_reg[j] == port)
                known_c = 1'b1;
        end
    end

    // free token ripples from the lowest cell upward
    assign free_out = free_in | ~valid_reg;
    assign claim    = op.act & op.insert & ~valid_reg & ~free_in;

    assign stat.hit   = hit_reg;
    assign stat.known = known_reg;
    assign stat.wrap  = wrap_reg;

    always_comb
    begin
        valid_next = valid_reg;
        if (op.act && op.clear)
            valid_next = 1'b0;
        else if (claim)
            valid_next = 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            hit_reg   <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
            if (op.look)
                hit_reg <= pkt & valid_reg & (key_reg == key);
        end
    end

    always_ff @(posedge clk)
    begin
        if (op.look)
        begin
            known_reg <= known_c;
            wrap_reg  <= (LW'(idx_reg) + LW'(1)) >= limit;
        end
        if (op.act && hit_reg && !known_reg)
        begin
            if (wrap_reg)
                idx_reg <= '0;
            else
            begin
                idx_reg                  <= idx_reg + IW'(1);
                ports_reg[idx_reg + IW'(1)] <= port;
            end
        end
        else if (claim)
        begin
            key_reg      <= key;
            idx_reg      <= '0;
            ports_reg[0] <= port;
        end
    end

endmodule

/* rtl/psd_alert_cell.sv */
// ----------------------------------------------------------------------------
// psd_alert_cell
// One entry of the alerted-pair list.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module psd_alert_cell
    import psd_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  cell_op_t            op,
    input  logic [KEY_BITS-1:0] key,
    input  logic                free_in,
    output logic                free_out,
    output logic                hit
);

    logic                valid_reg, valid_next;
    logic [KEY_BITS-1:0] key_reg;
    logic                hit_reg;
    logic                claim;

    assign free_out = free_in | ~valid_reg;
    assign claim    = op.act & op.insert & ~valid_reg & ~free_in;
    assign hit      = hit_reg;

    always_comb
    begin
        valid_next = valid_reg;
        if (op.act && op.clear)
            valid_next = 1'b0;
        else if (claim)
            valid_next = 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            hit_reg   <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
            if (op.look)
                hit_reg <= valid_reg & (key_reg == key);
        end
    end

    always_ff @(posedge clk)
    begin
        if (claim)
            key_reg <= key;
    end

endmodule

/* rtl/udp_port_scan_detector_unit.sv */
// ----------------------------------------------------------------------------
// udp_port_scan_detector_unit
// Flags address pairs that probe many distinct low UDP ports.
// ----------------------------------------------------------------------------
// Usage:
//   Input: drive item and pulse start while busy is low; the item is taken
//   on that edge and busy rises. command 0 is a packet header, command 1 a
//   minute tick that empties the pair table and the alerted-pair list.
//   Output: exactly one result per item, shown on result for one cycle with
//   done high. The receiver cannot stall; the result must be taken then.
//   Sequence: each item is latched, compared in all cells, then updated;
//   the compare and update passes go over the row of pair cells and
//   alert cells in parallel; a new item may start the cycle done is high.
//   Config: cfg_data (scan threshold) is taken when cfg_valid and cfg_ready
//   are high; cfg_ready is always high. Write only while idle.
//   Reset: rst_n clears all valid bits, threshold returns to 8, block idle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module udp_port_scan_detector_unit
    import psd_pkg::*;
#(
    parameter int PAIR_ENTRIES   = 64,
    parameter int PORTS_PER_PAIR = 16,
    parameter int ALERT_ENTRIES  = 16
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    output logic                busy,
    input  item_t               item,
    output logic                done,
    output result_t             result,
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic [THR_BITS-1:0] cfg_data
);

    localparam int LW = $clog2(PORTS_PER_PAIR + 1);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_LOOK = 2'd1;
    localparam logic [1:0] S_ACT  = 2'd2;

    logic [1:0]           state_reg, state_next;
    logic [THR_BITS-1:0]  thr_reg;
    item_t                item_reg;
    logic                 done_reg;
    result_t              result_reg;

    logic [KEY_BITS-1:0]  key;
    logic [PORT_BITS-1:0] port;
    logic                 pkt;
    logic [LW-1:0]        limit;

    cell_op_t             pop, aop;
    pair_stat_t           pstat [PAIR_ENTRIES];
    logic [PAIR_ENTRIES:0]  pfree;
    logic [ALERT_ENTRIES:0] afree;
    logic [ALERT_ENTRIES-1:0] ahit;
    logic                 any_hit, scan_cand, any_ahit;

    assign key  = {item_reg.src_ip, item_reg.dst_addr};
    assign port = item_reg.dst_port[PORT_BITS-1:0];
    assign pkt  = (item_reg.command == CMD_PACKET) &&
                  (item_reg.dst_port[15:PORT_BITS] == '0);
    assign limit = (32'(thr_reg) > 32'(PORTS_PER_PAIR)) ? LW'(PORTS_PER_PAIR)
                                                        : LW'(thr_reg);

    always_comb
    begin
        any_hit   = 1'b0;
        scan_cand = 1'b0;
        for (int i = 0; i < PAIR_ENTRIES; i++)
        begin
            any_hit   = any_hit | pstat[i].hit;
            scan_cand = scan_cand | (pstat[i].hit & ~pstat[i].known & pstat[i].wrap);
        end
    end

    assign any_ahit = |ahit;

    assign pop.look   = (state_reg == S_LOOK);
    assign pop.act    = (state_reg == S_ACT);
    assign pop.clear  = (item_reg.command == CMD_TICK);
    assign pop.insert = pkt & ~any_hit;

    assign aop.look   = pop.look;
    assign aop.act    = pop.act;
    assign aop.clear  = pop.clear;
    assign aop.insert = scan_cand & ~any_ahit;

    assign pfree[0] = 1'b0;
    assign afree[0] = 1'b0;

    for (genvar g = 0; g < PAIR_ENTRIES; g++)
    begin : g_pair
        psd_pair_cell #(
            .PORTS_PER_PAIR (PORTS_PER_PAIR),
            .LW             (LW)
        ) u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .op       (pop),
            .key      (key),
            .port     (port),
            .pkt      (pkt),
            .limit    (limit),
            .free_in  (pfree[g]),
            .free_out (pfree[g+1]),
            .stat     (pstat[g])
        );
    end

    for (genvar g = 0; g < ALERT_ENTRIES; g++)
    begin : g_alert
        psd_alert_cell u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .op       (aop),
            .key      (key),
            .free_in  (afree[g]),
            .free_out (afree[g+1]),
            .hit      (ahit[g])
        );
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:  if (start) state_next = S_LOOK;
            S_LOOK:  state_next = S_ACT;
            S_ACT:   state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            thr_reg   <= THR_RESET;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= pop.act;
            if (cfg_valid)
                thr_reg <= cfg_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == S_IDLE && start)
            item_reg <= item;
        if (pop.act)
        begin
            result_reg.scan_detected <= scan_cand & ~any_ahit;
            result_reg.table_full    <= pop.insert & ~pfree[PAIR_ENTRIES];
        end
    end

    assign busy      = (state_reg != S_IDLE);
    assign cfg_ready = 1'b1;
    assign done      = done_reg;
    assign result    = result_reg;

    a_done_after_act: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(state_reg) == S_ACT)
        else $error("result without update phase");

    a_one_flag: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !(result.scan_detected && result.table_full))
        else $error("scan and full together");

    a_single_hit: assert property (@(posedge clk) disable iff (!rst_n)
        pop.act |-> $onehot0(ahit))
        else $error("pair alerted twice");

    a_start_takes: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("item not taken");

endmodule

/* sim/tb_top.sv */
// ----------------------------------------------------------------------------
// tb_top
// Directed and randomized check of the UDP port scan detector against a
// behavioral predictor; packet headers and minute ticks are driven through
// start/busy, results are compared in order as they appear with done.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_top;
    import psd_pkg::*;

    localparam int PAIRS  = 64;
    localparam int SLOTS  = 16;
    localparam int ALERTS = 16;

    logic                clk = 1'b0;
    logic                rst_n = 1'b0;
    logic                start = 1'b0;
    logic                busy;
    item_t               item = '0;
    logic                done;
    result_t             result;
    logic                cfg_valid = 1'b0;
    logic                cfg_ready;
    logic [THR_BITS-1:0] cfg_data = '0;

    udp_port_scan_detector_unit i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .item      (item),
        .done      (done),
        .result    (result),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    always #1 clk = ~clk;

    // predictor state
    logic [THR_BITS-1:0] threshold;
    logic                pv [PAIRS];
    logic [63:0]         pkey [PAIRS];
    int unsigned         pidx [PAIRS];
    logic [9:0]          pport [PAIRS][SLOTS];
    logic                av [ALERTS];
    logic [63:0]         akey [ALERTS];

    item_t   pending_items [$];
    result_t expected_results [$];
    int      fail_count = 0;
    bit      driving = 1'b0;

    function automatic result_t scan_predict(item_t it);
        result_t     r;
        logic [63:0] key;
        int          hit;
        int          fr;
        int          af;
        int unsigned idx;
        int unsigned lim;
        bit          known;
        bit          seen;
        r = '0;
        key = {it.src_ip, it.dst_addr};
        hit = -1;
        fr = -1;
        if (it.command == CMD_TICK) begin
            for (int i = 0; i < PAIRS; i++) pv[i] = 1'b0;
            for (int i = 0; i < ALERTS; i++) av[i] = 1'b0;
            return r;
        end
        if (it.dst_port >= 16'd1024) return r;
        for (int i = 0; i < PAIRS; i++) begin
            if (pv[i]) begin
                if (hit < 0 && pkey[i] == key) hit = i;
            end
            else if (fr < 0) fr = i;
        end
        if (hit >= 0) begin
            idx = pidx[hit];
            lim = (threshold > SLOTS) ? SLOTS : threshold;
            if (idx >= SLOTS) idx = SLOTS - 1;
            known = 1'b0;
            for (int j = 0; j <= idx; j++)
                if (pport[hit][j] == it.dst_port[9:0]) known = 1'b1;
            if (!known) begin
                idx++;
                if (idx < lim) begin
                    pport[hit][idx] = it.dst_port[9:0];
                    pidx[hit] = idx;
                end
                else begin
                    pidx[hit] = 0;
                    seen = 1'b0;
                    af = -1;
                    for (int i = 0; i < ALERTS; i++) begin
                        if (av[i]) begin
                            if (akey[i] == key) seen = 1'b1;
                        end
                        else if (af < 0) af = i;
                    end
                    if (!seen) begin
                        r.scan_detected = 1'b1;
                        if (af >= 0) begin
                            av[af] = 1'b1;
                            akey[af] = key;
                        end
                    end
                end
            end
        end
        else if (fr >= 0) begin
            pv[fr] = 1'b1;
            pkey[fr] = key;
            pidx[fr] = 0;
            pport[fr][0] = it.dst_port[9:0];
        end
        else r.table_full = 1'b1;
        return r;
    endfunction

    function automatic int short_gap();
        int g;
        g = $urandom_range(0, 99);
        if (g < 60) return 0;
        if (g < 95) return $urandom_range(1, 3);
        return $urandom_range(5, 20);
    endfunction

    // driver
    int gap_left = 0;
    always @(posedge clk) begin
        if (start && !busy) begin
            expected_results.push_back(scan_predict(item));
        end
        if (start && busy) begin
            // hold the item until taken
        end
        else if (driving && gap_left > 0) begin
            gap_left <= gap_left - 1;
            start <= 1'b0;
        end
        else if (driving && pending_items.size() > 0) begin
            item <= pending_items.pop_front();
            start <= 1'b1;
            gap_left <= short_gap();
        end
        else begin
            start <= 1'b0;
        end
    end

    // monitor
    always @(posedge clk) begin
        if (rst_n && done) begin
            if (expected_results.size() == 0) begin
                $display("%0t: unexpected result %b", $realtime, result);
                fail_count++;
            end
            else begin
                result_t e;
                e = expected_results.pop_front();
                if (e.scan_detected !== result.scan_detected) begin
                    $display("%0t: scan_detected expected %b actual %b", $realtime,
                        e.scan_detected, result.scan_detected);
                    fail_count++;
                end
                if (e.table_full !== result.table_full) begin
                    $display("%0t: table_full expected %b actual %b", $realtime,
                        e.table_full, result.table_full);
                    fail_count++;
                end
            end
        end
    end

    function automatic item_t pkt(logic [31:0] s, logic [31:0] d, logic [15:0] p);
        item_t it;
        it.command = CMD_PACKET;
        it.src_ip = s;
        it.dst_addr = d;
        it.dst_port = p;
        return it;
    endfunction

    function automatic item_t tick_item();
        item_t it;
        it = '0;
        it.command = CMD_TICK;
        it.src_ip = $urandom;
        it.dst_addr = $urandom;
        it.dst_port = 16'($urandom);
        return it;
    endfunction

    task automatic drain();
        driving = 1'b1;
        while (pending_items.size() > 0 || start || busy || expected_results.size() > 0)
            @(posedge clk);
        driving = 1'b0;
        repeat (6) @(posedge clk);
    endtask

    task automatic write_threshold(logic [THR_BITS-1:0] v);
        cfg_data <= v;
        cfg_valid <= 1'b1;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        cfg_valid <= 1'b0;
        threshold = v;
        @(posedge clk);
    endtask

    // one random phase: a pool of pairs, mostly low ports drawn from a small set
    task automatic random_phase(int n, int npairs, int span);
        logic [31:0] src [];
        logic [31:0] dst [];
        int          k;
        int          r;
        logic [15:0] p;
        src = new[npairs];
        dst = new[npairs];
        for (int i = 0; i < npairs; i++) begin
            src[i] = $urandom;
            dst[i] = $urandom;
        end
        for (int i = 0; i < n; i++) begin
            r = $urandom_range(0, 99);
            k = $urandom_range(0, npairs - 1);
            if (r < 2) pending_items.push_back(tick_item());
            else if (r < 7) pending_items.push_back(pkt($urandom, $urandom, 16'($urandom)));
            else begin
                p = 16'($urandom_range(0, span - 1));
                if (r < 10) p = 16'($urandom_range(0, 1023));
                pending_items.push_back(pkt(src[k], dst[k], p));
            end
        end
    endtask

    initial begin
        threshold = THR_RESET;
        for (int i = 0; i < PAIRS; i++) pv[i] = 1'b0;
        for (int i = 0; i < ALERTS; i++) av[i] = 1'b0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: extremes, high ports, known ports, scan at reset threshold
        pending_items.push_back(pkt('0, '0, 16'd0));
        pending_items.push_back(pkt('0, '0, 16'd0));
        pending_items.push_back(pkt('1, '1, 16'd1023));
        pending_items.push_back(pkt('1, '1, 16'd1024));
        pending_items.push_back(pkt('1, '1, 16'hFFFF));
        for (int i = 1; i <= 8; i++) pending_items.push_back(pkt('0, '0, 16'(i)));
        pending_items.push_back(pkt('0, '0, 16'd8));
        for (int i = 9; i <= 17; i++) pending_items.push_back(pkt('0, '0, 16'(i)));
        pending_items.push_back(tick_item());
        drain();

        // threshold 0 and 1: a pair's second distinct port already flags a scan
        write_threshold(5'd0);
        for (int i = 0; i < 3; i++) pending_items.push_back(pkt(32'h1, 32'h2, 16'(i)));
        drain();
        write_threshold(5'd1);
        for (int i = 0; i < 3; i++) pending_items.push_back(pkt(32'h3, 32'h2, 16'(i)));
        drain();

        // fill the pair table, then overflow
        write_threshold(5'd2);
        for (int i = 0; i < PAIRS + 4; i++)
            pending_items.push_back(pkt(32'(i), 32'hA5A5_0000, 16'd5));
        // many distinct scanning pairs to overflow the alert list
        for (int i = 0; i < PAIRS; i++) begin
            pending_items.push_back(pkt(32'(i), 32'hA5A5_0000, 16'd6));
            pending_items.push_back(pkt(32'(i), 32'hA5A5_0000, 16'd7));
        end
        pending_items.push_back(tick_item());
        drain();

        // random phases across threshold settings, extremes included
        random_phase(300, 8, 24);
        drain();
        write_threshold(5'd16);
        random_phase(300, 6, 40);
        drain();
        write_threshold(5'd31);
        random_phase(300, 6, 40);
        drain();
        write_threshold(5'd4);
        random_phase(200, 70, 8);
        drain();
        write_threshold(5'd1);
        random_phase(200, 30, 6);
        drain();
        write_threshold(5'($urandom_range(0, 31)));
        random_phase(200, 12, 20);
        drain();

        repeat (20) @(posedge clk);
        if (fail_count == 0 && expected_results.size() == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

    initial begin
        #2000000;
        $display("FAIL");
        $finish;
    end

endmodule
